// ===== design/bpc_pkg.sv =====
// shared types and constants of the button press classifier
package bpc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_DATA_W = 16;
  localparam int BTN_W = 2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd500;
  localparam logic [BTN_W-1:0] FEATURED_RST = 2'd3;

  typedef enum logic [1:0] {
    KIND_SHORT  = 2'd0,
    KIND_LONG   = 2'd1,
    KIND_DOUBLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2,
    REG_FEATURED     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      debounce_ms;
    logic [15:0]      long_press_ms;
    logic [15:0]      double_click_ms;
    logic [BTN_W-1:0] featured_button;
  } cfg_t;

  typedef struct packed {
    logic              settled_level;
    logic [TIME_W-1:0] changed_at;
    logic [TIME_W-1:0] pressed_at;
    logic              long_fired;
    logic [TIME_W-1:0] last_short_time;
  } btn_state_t;

  localparam btn_state_t BTN_STATE_RST = '{
    settled_level:   1'b1,
    changed_at:      '0,
    pressed_at:      '0,
    long_fired:      1'b0,
    last_short_time: '0
  };

  typedef struct packed {
    btn_state_t state;
    logic       has_event;
    kind_t      kind;
  } upd_t;

endpackage

// ===== design/bpc_sample_if.sv =====
// input sample channel
interface bpc_sample_if import bpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BTN_W-1:0]  button_index;
  logic              raw_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, button_index, raw_level, now_ms, input ready);
  modport sink (input valid, button_index, raw_level, now_ms, output ready);
endinterface

// ===== design/bpc_result_if.sv =====
// event result channel
interface bpc_result_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] event_button;
  logic [1:0]       event_kind;

  modport source (output valid, event_button, event_kind, input ready);
  modport sink (input valid, event_button, event_kind, output ready);
endinterface

// ===== design/bpc_cfg_if.sv =====
// configuration write channel
interface bpc_cfg_if import bpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bpc_cfg_regs.sv =====
// configuration registers
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bpc_cfg_if.sink   cfg,
  output cfg_t      cfg_q
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.long_press_ms <= LONG_PRESS_RST;
      cfg_q.double_click_ms <= DOUBLE_CLICK_RST;
      cfg_q.featured_button <= FEATURED_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DEBOUNCE:     cfg_q.debounce_ms <= cfg.data;
        REG_LONG_PRESS:   cfg_q.long_press_ms <= cfg.data;
        REG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg.data;
        REG_FEATURED:     cfg_q.featured_button <= cfg.data[BTN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bpc_state_mem.sv =====
// per-button state memory with valid bits and write forwarding
module bpc_state_mem import bpc_pkg::*; #(
  parameter int MEM_DEPTH = 4,
  parameter int AW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  btn_state_t    wr_data,
  output btn_state_t    rd_state
);

  btn_state_t              mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]    entry_valid;
  btn_state_t              rd_data;
  logic                    rd_entry_valid;
  logic [AW-1:0]           rd_addr_q;
  logic                    wb_valid;
  logic [AW-1:0]           wb_addr;
  btn_state_t              wb_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_entry_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
        wb_valid <= 1'b1;
      end
      if (rd_en) begin
        rd_entry_valid <= entry_valid[rd_addr];
      end
    end
  end

  // last write kept for a read that raced it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr <= wr_addr;
      wb_data <= wr_data;
    end
  end

  always_comb begin
    if (wb_valid && wb_addr == rd_addr_q) begin
      rd_state = wb_data;
    end else if (!rd_entry_valid) begin
      rd_state = BTN_STATE_RST;
    end else begin
      rd_state = rd_data;
    end
  end

endmodule

// ===== design/bpc_update.sv =====
// debounce and press classification for one sample
module bpc_update import bpc_pkg::*; (
  input  btn_state_t        cur,
  input  cfg_t              cfg_q,
  input  logic [BTN_W-1:0]  button_index,
  input  logic              raw_level,
  input  logic [TIME_W-1:0] now_ms,
  output upd_t              upd
);

  logic              feat;
  logic              change;
  logic              pressing;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_short;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] hold_time;

  always_comb begin
    feat = (button_index == cfg_q.featured_button);
    since_change = now_ms - cur.changed_at;
    since_short = now_ms - cur.last_short_time;
    since_press = now_ms - cur.pressed_at;
    change = (raw_level != cur.settled_level) &&
             (since_change > {16'd0, cfg_q.debounce_ms});
    pressing = change && !raw_level;

    upd.state = cur;
    upd.has_event = 1'b0;
    upd.kind = KIND_SHORT;

    if (change) begin
      upd.state.settled_level = raw_level;
      upd.state.changed_at = now_ms;
      if (!raw_level) begin
        upd.state.pressed_at = now_ms;
        upd.state.long_fired = 1'b0;
      end else if (!cur.long_fired) begin
        upd.has_event = 1'b1;
        if (feat && since_short < {16'd0, cfg_q.double_click_ms}) begin
          upd.state.last_short_time = '0;
          upd.kind = KIND_DOUBLE;
        end else begin
          upd.state.last_short_time = now_ms;
          upd.kind = KIND_SHORT;
        end
      end
    end

    // hold measured from the press just accepted, if any
    hold_time = pressing ? '0 : since_press;
    if (feat && !raw_level && !upd.state.long_fired &&
        hold_time >= {16'd0, cfg_q.long_press_ms}) begin
      upd.state.long_fired = 1'b1;
      upd.has_event = 1'b1;
      upd.kind = KIND_LONG;
    end
  end

endmodule

// ===== design/button_press_classifier_unit.sv =====
// button press classifier: per-button debounce and short press, long press and double click on the featured button
// an accepted item is registered in the s1 stage and its event in the output register
// throughput: one item per cycle unless the result port stalls; state read and written
//   back through one memory port pair, with the last write forwarded to a same-button read
// reset: synchronous; every button reads as released with zero times
//   right after reset, and the registers take their default values
module button_press_classifier_unit import bpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic          clk,
  input  logic          rst,
  bpc_sample_if.sink    sample,
  bpc_result_if.source  result,
  bpc_cfg_if.sink       cfg
);

  // only indexes the input field can reach get an entry
  localparam int MEM_DEPTH = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cfg_t              cfg_q;
  btn_state_t        cur;
  upd_t              upd;
  logic              accept;
  logic              advance;
  logic              in_range;
  logic              s1_valid;
  logic              s1_in_range;
  logic [BTN_W-1:0]  s1_button;
  logic              s1_level;
  logic [TIME_W-1:0] s1_now;
  logic              out_valid;
  logic [BTN_W-1:0]  out_button;
  kind_t             out_kind;

  assign advance = !out_valid || result.ready;
  assign sample.ready = !s1_valid || advance;
  assign accept = sample.valid && sample.ready;
  assign in_range = (32'(sample.button_index) < NUM_BUTTONS);

  bpc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  bpc_state_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (sample.button_index[AW-1:0]),
    .wr_en    (s1_valid && s1_in_range && advance),
    .wr_addr  (s1_button[AW-1:0]),
    .wr_data  (upd.state),
    .rd_state (cur)
  );

  bpc_update u_upd (
    .cur          (cur),
    .cfg_q        (cfg_q),
    .button_index (s1_button),
    .raw_level    (s1_level),
    .now_ms       (s1_now),
    .upd          (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid && s1_in_range && upd.has_event;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= in_range;
      s1_button <= sample.button_index;
      s1_level <= sample.raw_level;
      s1_now <= sample.now_ms;
    end
    if (advance) begin
      out_button <= s1_button;
      out_kind <= upd.kind;
    end
  end

  assign result.valid = out_valid;
  assign result.event_button = out_button;
  assign result.event_kind = out_kind;

endmodule

// ===== design/bpc_checker.sv =====
// port-level checks of the classifier, bound to the top level
module bpc_checker import bpc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [BTN_W-1:0] event_button,
  input logic [1:0]       event_kind
);

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (event_kind == KIND_SHORT || event_kind == KIND_LONG ||
                      event_kind == KIND_DOUBLE))
    else $error("event kind out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(event_button) && $stable(event_kind))
    else $error("stalled event changed");

  a_event_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
    else $error("event without an accepted item two cycles before");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("input stalled while output is empty");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .event_button (result.event_button),
  .event_kind   (result.event_kind)
);
